FILE: rtl/core/thread_watchdog_timeout_table_core_macros.svh
// Assertion macros shared by the watchdog table RTL.
// The macros expect clk and rst_n in the scope that uses them.
`ifndef THREAD_WATCHDOG_TIMEOUT_TABLE_CORE_MACROS_SVH
`define THREAD_WATCHDOG_TIMEOUT_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TWDT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TWDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/twdt_pkg.sv
// Package for the watchdog timeout table: payload structs, codes and FSM states.
// No dependencies; used by twdt_ctrl, the top level and the testbench.
`timescale 1ns / 1ps

package twdt_pkg;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] worker;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] worker_id;
        logic [4:0] restart_count;
        logic       last;
    } result_t;

    localparam logic [1:0] FUNC_ARM    = 2'd0;
    localparam logic [1:0] FUNC_DISARM = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_CHECK  = 2'd3;

    localparam logic [2:0] KIND_ARMED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_DISARMED  = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_RESTART   = 3'd4;
    localparam logic [2:0] KIND_DONE      = 3'd5;

    localparam logic [15:0] TIMEOUT_RESET = 16'd30;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

FILE: rtl/core/twdt_slot_mem.sv
// Slot memory of the watchdog table: one write port, one read port, registered read.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module twdt_slot_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 40
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/twdt_ctrl.sv
// Sequencer of the watchdog table: slot scan, read-modify-write and result register.
// Depends on twdt_pkg and thread_watchdog_timeout_table_core_macros.svh.
`timescale 1ns / 1ps
`include "thread_watchdog_timeout_table_core_macros.svh"

module twdt_ctrl #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int TIME_BITS   = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  twdt_pkg::cmd_t            cmd,
    input  logic [15:0]               timeout,
    input  logic [TIME_BITS-1:0]      now_sec,
    output logic                      busy,
    output twdt_pkg::result_t         result,
    output logic                      result_valid,
    output logic                      mem_we,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] mem_wr_addr,
    output logic [ID_BITS+TIME_BITS-1:0] mem_wr_data,
    output logic                      mem_re,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] mem_rd_addr,
    input  logic [ID_BITS+TIME_BITS-1:0] mem_rd_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_DEPTH);

    twdt_pkg::state_t         state_reg, state_next;
    logic [1:0]               op_reg, op_next;
    logic [ID_BITS-1:0]       id_reg, id_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     pend_reg, pend_next;
    logic [IDX_W-1:0]         pend_idx_reg, pend_idx_next;
    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         found_idx_reg, found_idx_next;
    logic                     free_reg, free_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic [4:0]               count_reg, count_next;
    logic [TABLE_DEPTH-1:0]   valid_reg, valid_next;
    twdt_pkg::result_t        res_reg, res_next;
    logic                     res_valid_reg, res_valid_next;

    logic [ID_BITS-1:0]       rd_worker;
    logic [TIME_BITS-1:0]     rd_armed;
    logic [TIME_BITS-1:0]     elapsed;
    logic                     expired;
    logic                     pend_valid;
    logic                     scan_last;
    logic                     start_scan;

    assign rd_worker  = mem_rd_data[ID_BITS+TIME_BITS-1:TIME_BITS];
    assign rd_armed   = mem_rd_data[TIME_BITS-1:0];
    // Elapsed time wraps with the seconds counter, so the subtraction is modular.
    assign elapsed    = now_sec - rd_armed;
    assign expired    = (elapsed >= TIME_BITS'(timeout));
    assign pend_valid = valid_reg[pend_idx_reg];
    assign scan_last  = (cnt_reg == LAST_CNT);
    assign start_scan = accept && (cmd.func != twdt_pkg::FUNC_TICK);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            twdt_pkg::ST_IDLE:
            begin
                if (start_scan)
                begin
                    state_next = twdt_pkg::ST_SCAN;
                end
            end
            twdt_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = twdt_pkg::ST_FINISH;
                end
            end
            twdt_pkg::ST_FINISH:
            begin
                state_next = twdt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = twdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        id_next        = id_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        mem_we         = 1'b0;
        mem_wr_addr    = pend_idx_reg;
        mem_wr_data    = {rd_worker, now_sec};
        mem_re         = 1'b0;
        mem_rd_addr    = cnt_reg[IDX_W-1:0];

        case (state_reg)
            twdt_pkg::ST_IDLE:
            begin
                if (start_scan)
                begin
                    op_next    = cmd.func;
                    id_next    = ID_BITS'(cmd.worker);
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    count_next = '0;
                end
            end
            twdt_pkg::ST_SCAN:
            begin
                // Issue the read of the next slot while the previous one is evaluated.
                if (!scan_last)
                begin
                    mem_re        = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg[IDX_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (op_reg == twdt_pkg::FUNC_CHECK)
                    begin
                        if (pend_valid && expired)
                        begin
                            mem_we                 = 1'b1;
                            count_next             = count_reg + 5'd1;
                            res_valid_next         = 1'b1;
                            res_next.kind          = twdt_pkg::KIND_RESTART;
                            res_next.worker_id     = 8'(rd_worker);
                            res_next.restart_count = 5'd0;
                            res_next.last          = 1'b0;
                        end
                    end
                    else
                    begin
                        if (pend_valid && (rd_worker == id_reg) && !found_reg)
                        begin
                            found_next     = 1'b1;
                            found_idx_next = pend_idx_reg;
                        end
                        if (!pend_valid && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = pend_idx_reg;
                        end
                    end
                end
            end
            twdt_pkg::ST_FINISH:
            begin
                res_valid_next         = 1'b1;
                res_next.worker_id     = 8'(id_reg);
                res_next.restart_count = 5'd0;
                res_next.last          = 1'b1;
                mem_wr_data            = {id_reg, now_sec};
                case (op_reg)
                    twdt_pkg::FUNC_ARM:
                    begin
                        if (found_reg)
                        begin
                            mem_we        = 1'b1;
                            mem_wr_addr   = found_idx_reg;
                            res_next.kind = twdt_pkg::KIND_ARMED;
                        end
                        else if (free_reg)
                        begin
                            mem_we                  = 1'b1;
                            mem_wr_addr             = free_idx_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            res_next.kind           = twdt_pkg::KIND_ARMED;
                        end
                        else
                        begin
                            res_next.kind = twdt_pkg::KIND_FULL;
                        end
                    end
                    twdt_pkg::FUNC_DISARM:
                    begin
                        if (found_reg)
                        begin
                            valid_next[found_idx_reg] = 1'b0;
                            res_next.kind             = twdt_pkg::KIND_DISARMED;
                        end
                        else
                        begin
                            res_next.kind = twdt_pkg::KIND_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        res_next.kind          = twdt_pkg::KIND_DONE;
                        res_next.worker_id     = 8'd0;
                        res_next.restart_count = count_reg;
                    end
                endcase
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= twdt_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            res_valid_reg <= res_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        pend_idx_reg  <= pend_idx_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        count_reg     <= count_next;
        res_reg       <= res_next;
    end

    assign busy         = (state_reg != twdt_pkg::ST_IDLE);
    assign result       = res_reg;
    assign result_valid = res_valid_reg;

    `TWDT_ASSERT_SAME(a_last_idle, res_valid_reg && res_reg.last, !busy, "last while busy")
    `TWDT_ASSERT_SAME(a_rw_apart, mem_we && mem_re, mem_wr_addr != mem_rd_addr, "slot clash")
    `TWDT_ASSERT_SAME(a_idle_no_pend, !busy, !pend_reg, "pending read while idle")
    `TWDT_ASSERT_NEXT(a_start_scans, start_scan, state_reg == twdt_pkg::ST_SCAN, "no scan")

endmodule

FILE: rtl/core/thread_watchdog_timeout_table_core.sv
// Top level of the watchdog timeout table: timeout register, seconds counter,
// sequencer and slot memory. Depends on twdt_pkg, twdt_ctrl and twdt_slot_mem.
`timescale 1ns / 1ps

// Channel    Ports                          Transfer
// ---------  -----------------------------  --------------------------------------
// command    start, busy, cmd               rising edge with start high, busy low
// result     result_valid, result           every cycle result_valid is high
// config     timeout_we, timeout_wdata      rising edge with timeout_we high
//
// A tick transfer leaves busy low. Arm, disarm and check read every slot of the table
// through the single read port of the slot memory, one slot per cycle, so busy stays
// high through the scan and its finish step, and the next command can follow once busy
// is low again. The reset is asynchronous and active low; it empties the table, zeroes
// the seconds counter and loads a timeout of 30 seconds. The receiver of results cannot
// stall: each result is shown for one cycle.

module thread_watchdog_timeout_table_core #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int TIME_BITS   = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  twdt_pkg::cmd_t    cmd,
    input  logic              timeout_we,
    input  logic [15:0]       timeout_wdata,
    output twdt_pkg::result_t result,
    output logic              result_valid
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int WORD_W = ID_BITS + TIME_BITS;

    logic [15:0]          timeout_reg, timeout_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic                 accept;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic [WORD_W-1:0]    mem_wr_data;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic [WORD_W-1:0]    mem_rd_data;

    // A command transfers only while the sequencer is idle.
    assign accept = start && !busy;

    // The user must rewrite the timeout only while the block is idle, so a scan sees
    // a stable value; this is not enforced. The seconds counter wraps at TIME_BITS.
    always_comb
    begin
        timeout_next = timeout_reg;
        now_next     = now_reg;
        if (timeout_we)
        begin
            timeout_next = timeout_wdata;
        end
        if (accept && (cmd.func == twdt_pkg::FUNC_TICK))
        begin
            now_next = now_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= twdt_pkg::TIMEOUT_RESET;
            now_reg     <= '0;
        end
        else
        begin
            timeout_reg <= timeout_next;
            now_reg     <= now_next;
        end
    end

    // The sequencer owns the valid bits and walks the slot memory. Its reads go
    // in ascending order and each write-back hits a slot that was read earlier,
    // so a read and a write never meet on the same slot.
    twdt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cmd          (cmd),
        .timeout      (timeout_reg),
        .now_sec      (now_reg),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid),
        .mem_we       (mem_we),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_re       (mem_re),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    // Each slot word holds the worker id above the second at which it was armed.
    twdt_slot_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W)
    ) u_slot_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .re      (mem_re),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

FILE: bench/tb_thread_watchdog_timeout_table_core.sv
// Self-checking testbench for the watchdog timeout table core.
// Depends on twdt_pkg and thread_watchdog_timeout_table_core; checks every result
// against a behavioral prediction of table and seconds counter, or a hand-typed row.
`timescale 1ns / 1ps

module tb_thread_watchdog_timeout_table_core;

    localparam int DEPTH         = 16;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    // Settling time after the last result: a full busy spell, plus margin.
    localparam int SETTLE_CYCLES = DEPTH + 6;
    // Longest legal quiet spell is a sender gap, a full scan and a settling pause.
    localparam int QUIET_LIMIT   = 1000;
    localparam int PHASE_ITEMS   = 73;
    localparam int PHASE_COUNT   = 6;

    // One row of the directed stimulus table. When typed is set, the single
    // result of the row is written out by hand and used as the expectation.
    typedef struct {
        twdt_pkg::cmd_t    c;
        bit                typed;
        twdt_pkg::result_t want;
    } stim_row_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              start         = 1'b0;
    twdt_pkg::cmd_t    cmd           = '0;
    logic              timeout_we    = 1'b0;
    logic [15:0]       timeout_wdata = '0;
    logic              busy;
    twdt_pkg::result_t result;
    logic              result_valid;

    // Predicted copy of the table, the seconds counter and the timeout register.
    bit          wd_valid [DEPTH];
    logic [7:0]  wd_worker[DEPTH];
    logic [31:0] wd_armed [DEPTH];
    logic [31:0] now_sec;
    logic [15:0] timeout_cfg;

    // Results predicted for the latest command, and all results still owed.
    twdt_pkg::result_t step_results[$];
    twdt_pkg::result_t pending_results[$];
    int                error_count = 0;
    int                quiet_cycles = 0;

    thread_watchdog_timeout_table_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .timeout_we    (timeout_we),
        .timeout_wdata (timeout_wdata),
        .result        (result),
        .result_valid  (result_valid)
    );

    always #CLK_HALF clk = ~clk;

    function automatic twdt_pkg::result_t make_result(logic [2:0] kind, logic [7:0] id,
                                                      logic [4:0] cnt, logic fin);
        twdt_pkg::result_t r;
        r.kind          = kind;
        r.worker_id     = id;
        r.restart_count = cnt;
        r.last          = fin;
        return r;
    endfunction

    function automatic stim_row_t dir_row(logic [1:0] f, logic [7:0] id, bit typed,
                                          logic [2:0] kind);
        stim_row_t row;
        row.c.func   = f;
        row.c.worker = id;
        row.typed    = typed;
        // Hand-typed rows are all single-result commands; check done carries id zero.
        row.want     = make_result(kind, (kind == twdt_pkg::KIND_DONE) ? 8'd0 : id, 5'd0,
                                   1'b1);
        return row;
    endfunction

    // Returns the slot holding the given worker, or -1 when it is absent.
    function automatic int find_worker(logic [7:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (wd_valid[i] && wd_worker[i] == id)
                return i;
        return -1;
    endfunction

    // Applies one command to the predicted table and fills step_results with
    // the results it must produce, in order.
    function automatic void watchdog_step(twdt_pkg::cmd_t c);
        int         slot;
        logic [4:0] restarts;
        step_results.delete();
        restarts = '0;
        case (c.func)
            twdt_pkg::FUNC_ARM:
            begin
                slot = find_worker(c.worker);
                if (slot < 0)
                begin
                    // A new worker takes the lowest free slot.
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (!wd_valid[i])
                            slot = i;
                end
                if (slot < 0)
                    step_results.push_back(make_result(twdt_pkg::KIND_FULL, c.worker,
                                                       5'd0, 1'b1));
                else
                begin
                    wd_valid[slot]  = 1'b1;
                    wd_worker[slot] = c.worker;
                    wd_armed[slot]  = now_sec;
                    step_results.push_back(make_result(twdt_pkg::KIND_ARMED, c.worker,
                                                       5'd0, 1'b1));
                end
            end
            twdt_pkg::FUNC_DISARM:
            begin
                slot = find_worker(c.worker);
                if (slot < 0)
                    step_results.push_back(make_result(twdt_pkg::KIND_NOT_FOUND, c.worker,
                                                       5'd0, 1'b1));
                else
                begin
                    wd_valid[slot] = 1'b0;
                    step_results.push_back(make_result(twdt_pkg::KIND_DISARMED, c.worker,
                                                       5'd0, 1'b1));
                end
            end
            twdt_pkg::FUNC_TICK:
                now_sec = now_sec + 32'd1;
            default:
            begin
                // Elapsed time wraps with the 32-bit counter, so plain subtraction holds.
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (wd_valid[i] && (now_sec - wd_armed[i]) >= {16'd0, timeout_cfg})
                    begin
                        step_results.push_back(make_result(twdt_pkg::KIND_RESTART,
                                                           wd_worker[i], 5'd0, 1'b0));
                        restarts    = restarts + 5'd1;
                        wd_armed[i] = now_sec;
                    end
                end
                step_results.push_back(make_result(twdt_pkg::KIND_DONE, 8'd0, restarts,
                                                   1'b1));
            end
        endcase
    endfunction

    // Presents one command and holds it until the block takes it. The transfer
    // happens at the edge where start is high and busy is low; the expectations
    // are queued at that edge.
    task automatic issue(input twdt_pkg::cmd_t c, input bit typed,
                         input twdt_pkg::result_t want);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        watchdog_step(c);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
    endtask

    // The sender may pause after a transfer, except in stretches of
    // back-to-back commands.
    task automatic sender_gap(input int item_no);
        int gap;
        gap = (item_no % 64 < 12) ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drains the block before a register write. A tick leaves nothing owed, so
    // after the last result a further settling pause covers any scan in flight.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        timeout_we    <= 1'b1;
        timeout_wdata <= value;
        @(posedge clk);
        timeout_cfg = value;
        timeout_we <= 1'b0;
    endtask

    // Result checker: every strobed result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        twdt_pkg::result_t exp_r;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, result);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result.kind !== exp_r.kind)
                begin
                    $display("%0t: kind mismatch: expected %0d, actual %0d", $time,
                             exp_r.kind, result.kind);
                    error_count++;
                end
                if (result.worker_id !== exp_r.worker_id)
                begin
                    $display("%0t: worker_id mismatch: expected %0d, actual %0d", $time,
                             exp_r.worker_id, result.worker_id);
                    error_count++;
                end
                if (result.restart_count !== exp_r.restart_count)
                begin
                    $display("%0t: restart_count mismatch: expected %0d, actual %0d", $time,
                             exp_r.restart_count, result.restart_count);
                    error_count++;
                end
                if (result.last !== exp_r.last)
                begin
                    $display("%0t: last mismatch: expected %0d, actual %0d", $time,
                             exp_r.last, result.last);
                    error_count++;
                end
            end
        end
    end

    // Hang detector: counts cycles in which neither a command nor a result transfers.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        stim_row_t      directed[$];
        logic [15:0]    phase_timeout[PHASE_COUNT];
        twdt_pkg::cmd_t c;
        int             pick;
        int             item_no;

        foreach (wd_valid[i])
        begin
            wd_valid[i]  = 1'b0;
            wd_worker[i] = '0;
            wd_armed[i]  = '0;
        end
        now_sec     = '0;
        timeout_cfg = twdt_pkg::TIMEOUT_RESET;

        // Directed table. It runs with the reset timeout of 30 seconds.
        // A check of the empty table gives only check done with a zero count.
        directed.push_back(dir_row(twdt_pkg::FUNC_CHECK, 8'd0, 1'b1, twdt_pkg::KIND_DONE));
        // Disarm of a worker that was never armed.
        directed.push_back(dir_row(twdt_pkg::FUNC_DISARM, 8'd0, 1'b1,
                                   twdt_pkg::KIND_NOT_FOUND));
        // Both id extremes, then a re-arm of a present id, which must not duplicate it.
        directed.push_back(dir_row(twdt_pkg::FUNC_ARM, 8'd0, 1'b1, twdt_pkg::KIND_ARMED));
        directed.push_back(dir_row(twdt_pkg::FUNC_ARM, 8'd255, 1'b1, twdt_pkg::KIND_ARMED));
        directed.push_back(dir_row(twdt_pkg::FUNC_ARM, 8'd0, 1'b1, twdt_pkg::KIND_ARMED));
        // Fill the remaining fourteen slots.
        for (int i = 1; i <= DEPTH - 2; i++)
            directed.push_back(dir_row(twdt_pkg::FUNC_ARM, 8'(i), 1'b1,
                                       twdt_pkg::KIND_ARMED));
        // A new worker on a full table is turned away.
        directed.push_back(dir_row(twdt_pkg::FUNC_ARM, 8'd200, 1'b1, twdt_pkg::KIND_FULL));
        // Free the second slot, held by worker 255; the next new worker must land there.
        directed.push_back(dir_row(twdt_pkg::FUNC_DISARM, 8'd255, 1'b1,
                                   twdt_pkg::KIND_DISARMED));
        directed.push_back(dir_row(twdt_pkg::FUNC_ARM, 8'd200, 1'b1, twdt_pkg::KIND_ARMED));
        directed.push_back(dir_row(twdt_pkg::FUNC_TICK, 8'd170, 1'b0, twdt_pkg::KIND_DONE));
        directed.push_back(dir_row(twdt_pkg::FUNC_CHECK, 8'd85, 1'b0, twdt_pkg::KIND_DONE));

        // Zero timeout makes every entry expire at every check; the largest
        // timeout keeps every entry alive; the small ones give frequent expiries.
        phase_timeout[0] = 16'd0;
        phase_timeout[1] = 16'd1;
        phase_timeout[2] = 16'hFFFF;
        phase_timeout[3] = 16'd4;
        phase_timeout[4] = 16'($urandom_range(2, 12));
        phase_timeout[5] = twdt_pkg::TIMEOUT_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        item_no = 0;
        foreach (directed[i])
        begin
            issue(directed[i].c, directed[i].typed, directed[i].want);
            sender_gap(item_no);
            item_no++;
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_idle();
            write_timeout(phase_timeout[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Mostly a small id pool, so the table fills, re-arms and disarms
                // hit; the rest spans the whole id range.
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    c.func = twdt_pkg::FUNC_ARM;
                else if (pick < 55)
                    c.func = twdt_pkg::FUNC_DISARM;
                else if (pick < 85)
                    c.func = twdt_pkg::FUNC_TICK;
                else
                    c.func = twdt_pkg::FUNC_CHECK;
                if ($urandom_range(0, 9) < 7)
                    c.worker = 8'($urandom_range(0, 19));
                else
                    c.worker = 8'($urandom_range(0, 255));
                issue(c, 1'b0, '0);
                sender_gap(item_no);
                item_no++;
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/twdt_pkg.sv
rtl/core/twdt_slot_mem.sv
rtl/core/twdt_ctrl.sv
rtl/core/thread_watchdog_timeout_table_core.sv
bench/tb_thread_watchdog_timeout_table_core.sv
